/* src/packet_filter_ack_generator_macros.svh */
// assertion macros for the packet filter and acknowledge generator
`ifndef PACKET_FILTER_ACK_GENERATOR_MACROS_SVH
`define PACKET_FILTER_ACK_GENERATOR_MACROS_SVH
`ifndef ASSERT_OFF
// checked after reset only
`define PFAG_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked at every edge, reset included
`define PFAG_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define PFAG_ASSERT(name, prop, msg)
`define PFAG_ASSERT_ALWAYS(name, prop, msg)
`endif
`endif

/* src/pfag_pkg.sv */
// shared types, constants and helpers of the packet filter and acknowledge generator
package pfag_pkg;

  localparam int unsigned MaxFrameDefault = 255;
  localparam int unsigned CountW          = 8;
  localparam int unsigned IdxW            = 5;
  localparam int unsigned CfgIdxW         = 2;
  localparam int unsigned CfgDataW        = 16;

  localparam logic [4:0] HdrCap = 5'd16;
  localparam logic [7:0] MinAccept  = 8'd12;
  localparam logic [7:0] MinDeliver = 8'd14;
  localparam logic [4:0] BuiltMax   = 5'd26;

  // header byte positions of a received frame
  localparam logic [CountW-1:0] PosIdLo   = CountW'(4);
  localparam logic [CountW-1:0] PosIdHi   = CountW'(5);
  localparam logic [CountW-1:0] PosProto  = CountW'(6);
  localparam logic [CountW-1:0] PosSrcLo  = CountW'(8);
  localparam logic [CountW-1:0] PosSrcHi  = CountW'(9);
  localparam logic [CountW-1:0] PosDstLo  = CountW'(10);
  localparam logic [CountW-1:0] PosDstHi  = CountW'(11);

  // protocol codes
  localparam logic [7:0] ProtoAckOnly = 8'd2;
  localparam logic [7:0] ProtoEsp     = 8'd5;
  localparam logic [7:0] ProtoNoAck   = 8'd9;

  // fields of built frames
  localparam logic [7:0] ProtoOfAck = 8'd1;
  localparam logic [7:0] ProtoOfOk  = 8'd0;
  localparam logic [7:0] CmdAck     = 8'd1;
  localparam logic [7:0] CmdOk      = 8'd2;
  localparam logic [7:0] LenAck     = 8'd2;
  localparam logic [7:0] LenOk      = 8'd6;

  typedef enum logic [1:0] {
    KIND_VERDICT = 2'd0,
    KIND_ACK     = 2'd1,
    KIND_OK      = 2'd2
  } frame_kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MY_ADDR    = 2'd0,
    REG_BCAST_ADDR = 2'd1,
    REG_HDR_LEN    = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       rx_last;
  } pfag_in_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    frame_kind_e frame_kind;
    logic        frame_end;
    logic        run_end;
    logic        accepted;
    logic        deliver;
  } pfag_out_t;

  typedef struct packed {
    logic [15:0] my_addr;
    logic [15:0] bcast_addr;
    logic [4:0]  hdr_len;
  } pfag_cfg_t;

  // verdict and reply job handed from capture to emitter at frame end
  typedef struct packed {
    logic        accepted;
    logic        deliver;
    logic        do_ack;
    logic        do_ok;
    logic [15:0] frame_id;
    logic [15:0] src_addr;
  } pfag_job_t;

  // payload text of the ok reply
  function automatic logic [7:0] ok_char(input logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd0:    c = 8'h45;
      3'd1:    c = 8'h53;
      3'd2:    c = 8'h50;
      3'd3:    c = 8'h5F;
      3'd4:    c = 8'h4F;
      3'd5:    c = 8'h4B;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

/* src/pfag_capture.sv */
// byte counter, header capture and frame-end verdict of received frames
`include "packet_filter_ack_generator_macros.svh"

module pfag_capture import pfag_pkg::*; #(
  parameter int unsigned MaxFrame = MaxFrameDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  pfag_cfg_t cfg_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  pfag_in_t  in_data_i,
  output logic      job_valid_o,
  output pfag_job_t job_o,
  input  logic      job_ready_i
);

  logic [CountW-1:0] count_q, count_d, count_inc;
  logic [15:0]       fid_q, fid_d, src_q, src_d, dst_q, dst_d;
  logic [7:0]        proto_q, proto_d;
  logic              job_valid_q, job_valid_d;
  pfag_job_t         job_q, job_d;
  logic              in_fire, mine, acc, del;

  assign in_ready_o  = !job_valid_q || job_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign job_valid_o = job_valid_q;
  assign job_o       = job_q;

  assign count_inc = (count_q < CountW'(MaxFrame)) ? count_q + CountW'(1) : count_q;

  always_comb begin
    fid_d   = fid_q;
    src_d   = src_q;
    dst_d   = dst_q;
    proto_d = proto_q;
    count_d = count_q;
    if (in_fire) begin
      case (count_q)
        PosIdLo:  fid_d[7:0]  = in_data_i.rx_byte;
        PosIdHi:  fid_d[15:8] = in_data_i.rx_byte;
        PosProto: proto_d     = in_data_i.rx_byte;
        PosSrcLo: src_d[7:0]  = in_data_i.rx_byte;
        PosSrcHi: src_d[15:8] = in_data_i.rx_byte;
        PosDstLo: dst_d[7:0]  = in_data_i.rx_byte;
        PosDstHi: dst_d[15:8] = in_data_i.rx_byte;
        default:  ;
      endcase
      count_d = in_data_i.rx_last ? '0 : count_inc;
    end
  end

  // verdict from the header as it stands after this byte
  always_comb begin
    mine = (dst_d == cfg_i.my_addr);
    acc  = (count_inc >= MinAccept) && (mine || (dst_d == cfg_i.bcast_addr));
    del  = acc && mine && (count_inc >= MinDeliver);
    job_d.accepted = acc;
    job_d.deliver  = del;
    job_d.do_ack   = del && ((proto_d == ProtoAckOnly) ||
                             ((proto_d >= ProtoEsp) && (proto_d != ProtoNoAck)));
    job_d.do_ok    = del && (proto_d == ProtoEsp);
    job_d.frame_id = fid_d;
    job_d.src_addr = src_d;
  end

  always_comb begin
    job_valid_d = job_valid_q;
    if (job_valid_q && job_ready_i) begin
      job_valid_d = 1'b0;
    end
    if (in_fire && in_data_i.rx_last) begin
      job_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      fid_q       <= '0;
      src_q       <= '0;
      dst_q       <= '0;
      proto_q     <= '0;
      job_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      fid_q       <= fid_d;
      src_q       <= src_d;
      dst_q       <= dst_d;
      proto_q     <= proto_d;
      job_valid_q <= job_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && in_data_i.rx_last) begin
      job_q <= job_d;
    end
  end

  `PFAG_ASSERT(a_count_sat, count_q <= CountW'(MaxFrame), "byte count past max frame")
  `PFAG_ASSERT(a_last_clears, in_fire && in_data_i.rx_last |=> count_q == '0 && job_valid_q,
               "frame end did not post a job")
  `PFAG_ASSERT(a_job_deliver, job_valid_q |-> !job_q.deliver || job_q.accepted,
               "deliver without accept")

endmodule

/* src/pfag_emitter.sv */
// verdict and reply frame builder with output register
`include "packet_filter_ack_generator_macros.svh"

module pfag_emitter import pfag_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  pfag_cfg_t cfg_i,
  input  logic      job_valid_i,
  input  pfag_job_t job_i,
  output logic      job_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output pfag_out_t out_data_o
);

  logic              busy_q, busy_d;
  frame_kind_e       kind_q, kind_d;
  logic [IdxW-1:0]   idx_q, idx_d, pidx;
  pfag_job_t         job_q, job_d;
  logic [15:0]       pid_q, pid_d;
  logic              out_valid_q, out_valid_d;
  pfag_out_t         out_q, out_d, step;

  logic [4:0] hl;
  logic [7:0] lng, total, proto, cmd, csum, payload, fbyte;
  logic       frame_last, advance, load;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // frame layout for the current byte
  always_comb begin
    hl    = (cfg_i.hdr_len > HdrCap) ? HdrCap : cfg_i.hdr_len;
    lng   = (kind_q == KIND_ACK) ? LenAck : LenOk;
    total = 8'(hl) + 8'd4 + lng;
    proto = (kind_q == KIND_ACK) ? ProtoOfAck : ProtoOfOk;
    cmd   = (kind_q == KIND_ACK) ? CmdAck : CmdOk;
    csum  = ~(total + pid_q[7:0] + pid_q[15:8] + proto);
    pidx  = idx_q - IdxW'(14);
    if (kind_q == KIND_ACK) begin
      payload = (pidx == IdxW'(0)) ? job_q.frame_id[7:0] :
                (pidx == IdxW'(1)) ? job_q.frame_id[15:8] : 8'h00;
    end else begin
      payload = (pidx < IdxW'(6)) ? ok_char(pidx[2:0]) : 8'h00;
    end
    case (idx_q)
      5'd2:    fbyte = total;
      5'd4:    fbyte = pid_q[7:0];
      5'd5:    fbyte = pid_q[15:8];
      5'd6:    fbyte = proto;
      5'd7:    fbyte = csum;
      5'd8:    fbyte = cfg_i.my_addr[7:0];
      5'd9:    fbyte = cfg_i.my_addr[15:8];
      5'd10:   fbyte = job_q.src_addr[7:0];
      5'd11:   fbyte = job_q.src_addr[15:8];
      5'd12:   fbyte = cmd;
      5'd13:   fbyte = lng;
      default: fbyte = (idx_q >= 5'd14) ? payload : 8'h00;
    endcase
    frame_last = ((8'(idx_q) + 8'd1) == total);
  end

  always_comb begin
    step.accepted = job_q.accepted;
    step.deliver  = job_q.deliver;
    if (kind_q == KIND_VERDICT) begin
      step.out_byte   = 8'h00;
      step.frame_kind = KIND_VERDICT;
      step.frame_end  = 1'b0;
      step.run_end    = 1'b1;
    end else begin
      step.out_byte   = fbyte;
      step.frame_kind = kind_q;
      step.frame_end  = frame_last;
      step.run_end    = frame_last && !((kind_q == KIND_ACK) && job_q.do_ok);
    end
  end

  assign advance     = busy_q && (!out_valid_q || out_ready_i);
  assign job_ready_o = !busy_q || (advance && step.run_end);
  assign load        = job_valid_i && job_ready_o;

  always_comb begin
    busy_d      = busy_q;
    kind_d      = kind_q;
    idx_d       = idx_q;
    job_d       = job_q;
    pid_d       = pid_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (advance) begin
      out_valid_d = 1'b1;
      out_d       = step;
      if ((kind_q != KIND_VERDICT) && frame_last) begin
        pid_d = pid_q + 16'd1;
      end
      if (step.run_end) begin
        busy_d = 1'b0;
      end else if (frame_last) begin
        kind_d = KIND_OK;
        idx_d  = '0;
      end else begin
        idx_d = idx_q + IdxW'(1);
      end
    end
    if (load) begin
      busy_d = 1'b1;
      job_d  = job_i;
      idx_d  = '0;
      kind_d = job_i.do_ack ? KIND_ACK : (job_i.do_ok ? KIND_OK : KIND_VERDICT);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      kind_q      <= KIND_VERDICT;
      idx_q       <= '0;
      job_q       <= '0;
      pid_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      busy_q      <= busy_d;
      kind_q      <= kind_d;
      idx_q       <= idx_d;
      job_q       <= job_d;
      pid_q       <= pid_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  `PFAG_ASSERT(a_idx_range, idx_q < BuiltMax, "byte index past longest frame")
  `PFAG_ASSERT(a_verdict_shape,
               out_valid_q && out_q.frame_kind == KIND_VERDICT |->
               out_q.out_byte == 8'h00 && !out_q.frame_end && out_q.run_end,
               "malformed verdict item")
  `PFAG_ASSERT(a_pid_step,
               advance && kind_q != KIND_VERDICT && frame_last |=> pid_q == $past(pid_q) + 16'd1,
               "packet id not advanced at frame end")
  `PFAG_ASSERT(a_out_deliver, out_valid_q |-> !out_q.deliver || out_q.accepted,
               "deliver without accept on output")

endmodule

/* src/packet_filter_ack_generator.sv */
// top level of the received-frame filter and acknowledge generator
// Takes one received byte per cycle with a last-byte flag and answers each frame end with
// either a single verdict item or the bytes of an acknowledge frame, optionally followed by
// an ok reply frame. Non-final bytes give no output and are taken every cycle, also while a
// reply is still being sent; a final byte yields one item per cycle while the output is ready,
// from one (verdict) up to hdr+6 plus hdr+10 bytes (at most 48), limited by the single
// byte-wide frame builder. Once a frame end's job is waiting for a busy builder, every input
// byte is stalled until the builder takes that job. A frame end's job passes through the
// job register and the builder state into the output register. Configuration registers are
// written through a plain write port and must only change while the block is idle.
module packet_filter_ack_generator import pfag_pkg::*; #(
  parameter int unsigned MaxFrame = MaxFrameDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // received bytes
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pfag_in_t            in_data_i,
  // result items
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pfag_out_t           out_data_o,
  // configuration writes
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  pfag_cfg_t cfg_q, cfg_d;
  pfag_job_t job;
  logic      job_valid, job_ready;

  // configuration registers; an unused index is ignored
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MY_ADDR:    cfg_d.my_addr    = cfg_data_i;
        REG_BCAST_ADDR: cfg_d.bcast_addr = cfg_data_i;
        REG_HDR_LEN:    cfg_d.hdr_len    = cfg_data_i[4:0];
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.my_addr    <= 16'd8;
      cfg_q.bcast_addr <= 16'hFFFF;
      cfg_q.hdr_len    <= 5'd12;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // length count, header capture and verdict, posted as one job per frame
  pfag_capture #(
    .MaxFrame (MaxFrame)
  ) u_capture (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .job_valid_o (job_valid),
    .job_o       (job),
    .job_ready_i (job_ready)
  );

  // walks each job byte by byte into the output register
  pfag_emitter u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (job_valid),
    .job_i       (job),
    .job_ready_o (job_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* bench/packet_filter_ack_generator_test.sv */
// testbench of the frame filter and acknowledge generator: directed and random frames, scoreboard
`timescale 1ns / 1ps

module packet_filter_ack_generator_test import pfag_pkg::*;;

  // run bounds
  localparam int CycleLimit = 300000;
  localparam int TailCycles = 8;
  localparam int PhaseItems = 20;
  localparam int LongHold   = 300;
  // "ESP_OK", first character in the low byte
  localparam logic [47:0] EspOkText = 48'h4B4F5F505345;

  // filter state, config copy and the queue of reply items still to come
  class reply_scoreboard;
    logic [15:0] my_addr;
    logic [15:0] bcast_addr;
    logic [4:0]  hdr_len;
    logic [7:0]  byte_count;
    logic [15:0] frame_id;
    logic [7:0]  proto;
    logic [15:0] src_addr;
    logic [15:0] dst_addr;
    logic [15:0] next_pid;
    pfag_out_t   awaited_items[$];
    pfag_out_t   reply_run[$];
    int          mismatches;

    function new();
      my_addr    = 16'd8;
      bcast_addr = 16'hFFFF;
      hdr_len    = 5'd12;
      byte_count = '0;
      frame_id   = '0;
      proto      = '0;
      src_addr   = '0;
      dst_addr   = '0;
      next_pid   = '0;
      mismatches = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [15:0] val);
      case (idx)
        REG_MY_ADDR:    my_addr = val;
        REG_BCAST_ADDR: bcast_addr = val;
        REG_HDR_LEN:    hdr_len = val[4:0];
        default: ;
      endcase
    endfunction

    // one built frame, its bytes appended to reply_run
    function void add_frame(frame_kind_e kind, logic [7:0] fproto, logic [7:0] cmd,
                            logic [7:0] lng, logic [47:0] payload, logic acc, logic del);
      logic [7:0] f [0:31];
      logic [7:0] sum;
      int         hl;
      int         total;
      pfag_out_t  r;
      hl = (hdr_len > HdrCap) ? int'(HdrCap) : int'(hdr_len);
      total = hl + 4 + int'(lng);
      foreach (f[i]) f[i] = 8'h00;
      f[2] = total[7:0];
      f[4] = next_pid[7:0];
      f[5] = next_pid[15:8];
      f[6] = fproto;
      next_pid = next_pid + 16'd1;
      sum = 8'h00;
      for (int i = 0; i < 7; i++) sum = sum + f[i];
      f[7]  = ~sum;
      f[8]  = my_addr[7:0];
      f[9]  = my_addr[15:8];
      f[10] = src_addr[7:0];
      f[11] = src_addr[15:8];
      f[12] = cmd;
      f[13] = lng;
      for (int i = 0; i < int'(lng) && 14 + i < 32; i++) f[14 + i] = payload[8*i +: 8];
      for (int i = 0; i < total && i < 32; i++) begin
        r.out_byte   = f[i];
        r.frame_kind = kind;
        r.frame_end  = (i + 1 == total);
        r.run_end    = 1'b0;
        r.accepted   = acc;
        r.deliver    = del;
        reply_run.push_back(r);
      end
    endfunction

    function void take_rx_byte(pfag_in_t item);
      logic [7:0] b;
      logic [7:0] n;
      logic       mine;
      logic       acc;
      logic       del;
      pfag_out_t  r;
      b = item.rx_byte;
      case (byte_count)
        PosIdLo:  frame_id[7:0]  = b;
        PosIdHi:  frame_id[15:8] = b;
        PosProto: proto          = b;
        PosSrcLo: src_addr[7:0]  = b;
        PosSrcHi: src_addr[15:8] = b;
        PosDstLo: dst_addr[7:0]  = b;
        PosDstHi: dst_addr[15:8] = b;
        default: ;
      endcase
      if (byte_count < MaxFrameDefault) byte_count = byte_count + 8'd1;
      if (!item.rx_last) return;
      n = byte_count;
      byte_count = '0;
      mine = (dst_addr == my_addr);
      acc  = (n >= MinAccept) && (mine || dst_addr == bcast_addr);
      del  = acc && mine && (n >= MinDeliver);
      reply_run.delete();
      if (del) begin
        if (proto == ProtoAckOnly || (proto >= ProtoEsp && proto != ProtoNoAck))
          add_frame(KIND_ACK, ProtoOfAck, CmdAck, LenAck, {32'h0, frame_id}, acc, del);
        if (proto == ProtoEsp)
          add_frame(KIND_OK, ProtoOfOk, CmdOk, LenOk, EspOkText, acc, del);
      end
      if (reply_run.size() == 0) begin
        r = '0;
        r.frame_kind = KIND_VERDICT;
        r.accepted   = acc;
        r.deliver    = del;
        reply_run.push_back(r);
      end
      reply_run[reply_run.size() - 1].run_end = 1'b1;
      foreach (reply_run[i]) awaited_items.push_back(reply_run[i]);
    endfunction

    function void check_reply(pfag_out_t got);
      pfag_out_t exp;
      if (awaited_items.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result item: byte %h kind %0d end %b run %b acc %b del %b",
                   got.out_byte, got.frame_kind, got.frame_end, got.run_end,
                   got.accepted, got.deliver);
        return;
      end
      exp = awaited_items.pop_front();
      if (got.out_byte !== exp.out_byte || got.frame_kind !== exp.frame_kind ||
          got.frame_end !== exp.frame_end || got.run_end !== exp.run_end ||
          got.accepted !== exp.accepted || got.deliver !== exp.deliver) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: exp byte %h kind %0d end %b run %b acc %b del %b",
                   exp.out_byte, exp.frame_kind, exp.frame_end, exp.run_end,
                   exp.accepted, exp.deliver);
          $display("          got byte %h kind %0d end %b run %b acc %b del %b",
                   got.out_byte, got.frame_kind, got.frame_end, got.run_end,
                   got.accepted, got.deliver);
        end
      end
    endfunction

    function int pending();
      return awaited_items.size();
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  pfag_in_t            in_data_i;
  logic                out_valid_o;
  logic                out_ready_i;
  pfag_out_t           out_data_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  reply_scoreboard replies = new();

  int cycle_count = 0;
  int items_sent  = 0;
  // idling switches per phase and the long receiver hold-off request
  bit tx_gaps_on  = 1'b1;
  bit rx_gaps_on  = 1'b1;
  int hold_req    = 0;
  int stall_left  = 0;

  packet_filter_ack_generator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("packet_filter_ack_generator_test NOT OK");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  // result side: sample at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) replies.check_reply(out_data_o);
  end

  // result side: ready driven at the falling edge, long hold-off counted here
  always @(negedge clk_i) begin
    if (hold_req > 0) begin
      stall_left = hold_req;
      hold_req = 0;
    end
    if (stall_left == 0 && rx_gaps_on && $urandom_range(0, 5) == 0) stall_left = gap_len();
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // one received byte; called and returns at a falling edge
  task automatic send_byte(logic [7:0] b, logic last);
    pfag_in_t item;
    int       gap;
    item.rx_byte = b;
    item.rx_last = last;
    gap = (tx_gaps_on && $urandom_range(0, 4) == 0) ? gap_len() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    replies.take_rx_byte(item);
    items_sent++;
    @(negedge clk_i);
  endtask

  // frame with proto and destination at their header slots; fill below zero means random
  task automatic send_frame(int len, logic [15:0] dst, logic [7:0] fproto, int fill);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      b = (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
      case (i)
        6:  b = fproto;
        10: b = dst[7:0];
        11: b = dst[15:8];
        default: ;
      endcase
      send_byte(b, i == len - 1);
    end
  endtask

  function automatic int pick_len();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 2) return $urandom_range(1, 11);       // too short, dropped
    if (sel < 4) return $urandom_range(12, 13);      // accepted, never delivered
    if (sel < 17) return $urandom_range(14, 20);
    return $urandom_range(21, 60);
  endfunction

  function automatic logic [15:0] pick_dst();
    int sel;
    sel = $urandom_range(0, 7);
    if (sel < 4) return replies.my_addr;
    if (sel < 6) return replies.bcast_addr;
    if (sel == 6) return 16'($urandom_range(0, 65535));
    return replies.my_addr ^ (16'h1 << $urandom_range(0, 15));  // one bit off
  endfunction

  function automatic logic [7:0] pick_proto();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 3) return ProtoEsp;
    if (sel == 3) return ProtoAckOnly;
    if (sel == 4) return ProtoNoAck;
    if (sel == 5) return 8'($urandom_range(0, 12));
    return 8'($urandom_range(0, 255));
  endfunction

  // well-formed frames with random content, plus short and odd ones
  task automatic random_frames(int n_items);
    int start;
    start = items_sent;
    while (items_sent - start < n_items) send_frame(pick_len(), pick_dst(), pick_proto(), -1);
  endtask

  // sender holds off until every expected item has come, then lets the block settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (replies.pending() > 0) @(negedge clk_i);
    repeat (TailCycles) @(negedge clk_i);
  endtask

  // all three registers, write enable held across the burst
  task automatic write_settings(logic [15:0] my, logic [15:0] bc, logic [4:0] hl);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_MY_ADDR;
    cfg_data_i <= my;
    replies.write_reg(REG_MY_ADDR, my);
    @(negedge clk_i);
    cfg_idx_i  <= REG_BCAST_ADDR;
    cfg_data_i <= bc;
    replies.write_reg(REG_BCAST_ADDR, bc);
    @(negedge clk_i);
    cfg_idx_i  <= REG_HDR_LEN;
    cfg_data_i <= {11'h0, hl};
    replies.write_reg(REG_HDR_LEN, {11'h0, hl});
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  initial begin
    logic [15:0] addr;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_ready_i = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = REG_MY_ADDR;
    cfg_data_i  = '0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed, reset settings: lone byte dropped, esp frame to us with all-ones bytes,
    // minimum-length broadcast with all-zero bytes
    send_frame(1, 16'h0000, 8'h00, 0);
    send_frame(14, 16'd8, ProtoEsp, 255);
    send_frame(12, 16'hFFFF, ProtoAckOnly, 0);
    random_frames(PhaseItems);
    drain();

    // no idling on either side, zero address, smallest nominal header
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    write_settings(16'h0000, 16'hFFFF, 5'd8);
    random_frames(PhaseItems);
    drain();
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;

    // long receiver hold-off while frames keep coming, so the input backs up
    write_settings(16'hFFFF, 16'h0000, 5'd16);
    hold_req = LongHold;
    random_frames(PhaseItems);
    drain();

    // header length past the cap, sender pause halfway
    write_settings(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), 5'd31);
    random_frames(PhaseItems / 2);
    drain();
    random_frames(PhaseItems / 2);
    drain();

    // own address doubles as broadcast, header length zero
    addr = 16'($urandom_range(0, 65535));
    write_settings(addr, addr, 5'd0);
    random_frames(PhaseItems);
    drain();

    // short header below the fixed fields
    write_settings(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), 5'd7);
    random_frames(PhaseItems);
    drain();

    // just past the cap, then a random nominal header
    write_settings(16'($urandom_range(0, 65535)), 16'hFFFF, 5'd17);
    random_frames(PhaseItems);
    drain();
    write_settings(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                   5'($urandom_range(8, 16)));
    random_frames(PhaseItems);
    drain();

    if (replies.mismatches == 0 && replies.pending() == 0) begin
      $display("packet_filter_ack_generator_test OK");
    end else begin
      $display("packet_filter_ack_generator_test NOT OK");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+src
src/pfag_pkg.sv
src/pfag_capture.sv
src/pfag_emitter.sv
src/packet_filter_ack_generator.sv
bench/packet_filter_ack_generator_test.sv
